>>> sv/bitmap_block_allocator_top_assert.svh
// Assertion macros for the bitmap block allocator.
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define BBAL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define BBAL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/bbal_pkg.sv
// Shared constants and code types for the bitmap block allocator.
`timescale 1ns / 1ps

package bbal_pkg;

    // Map word geometry
    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;

    // Transaction field widths
    localparam int CMD_W    = 2;
    localparam int BLKNUM_W = 11;
    localparam int STATUS_W = 2;
    localparam int GRANT_W  = 10;
    localparam int TOTAL_W  = 11;

    // Parameter defaults
    localparam int NUM_BLOCKS_DEF     = 1024;
    localparam int RESERVED_FIRST_DEF = 1022;
    localparam int RESERVED_COUNT_DEF = 2;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    // Command codes
    localparam t_cmd CMD_ALLOC   = 2'd0;
    localparam t_cmd CMD_REQUEST = 2'd1;
    localparam t_cmd CMD_RELEASE = 2'd2;

    // Status codes
    localparam t_status STAT_OK      = 2'd0;
    localparam t_status STAT_NO_FREE = 2'd1;
    localparam t_status STAT_RANGE   = 2'd2;
    localparam t_status STAT_IN_USE  = 2'd3;

endpackage

>>> sv/bbal_cmd_if.sv
// Command channel: valid/ready with command and block number.
`timescale 1ns / 1ps

interface bbal_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [bbal_pkg::CMD_W-1:0]    command;
    logic [bbal_pkg::BLKNUM_W-1:0] block_number;

    modport source (output valid, output command, output block_number, input ready);
    modport sink   (input valid, input command, input block_number, output ready);
endinterface

>>> sv/bbal_rsp_if.sv
// Response channel: valid/ready with status, granted block and totals.
`timescale 1ns / 1ps

interface bbal_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bbal_pkg::STATUS_W-1:0] status;
    logic [bbal_pkg::GRANT_W-1:0]  granted_block;
    logic [bbal_pkg::TOTAL_W-1:0]  used_total;
    logic [bbal_pkg::TOTAL_W-1:0]  free_total;

    modport source (output valid, output status, output granted_block,
                    output used_total, output free_total, input ready);
    modport sink   (input valid, input status, input granted_block,
                    input used_total, input free_total, output ready);
endinterface

>>> sv/bbal_map_ram.sv
// Used/free map storage: one write port, one registered read port.
`timescale 1ns / 1ps

module bbal_map_ram #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic [bbal_pkg::WORD_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]           i_raddr,
    output logic [bbal_pkg::WORD_W-1:0] o_rdata
);

    logic [bbal_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [bbal_pkg::WORD_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/bbal_ffz.sv
// Find-first-zero over one map word: lowest clear bit and its position.
`timescale 1ns / 1ps

module bbal_ffz (
    input  logic [bbal_pkg::WORD_W-1:0] i_word,
    output logic                        o_found,
    output logic [bbal_pkg::BIT_W-1:0]  o_pos
);

    // Scan from the top so the lowest clear bit wins
    always_comb begin
        o_found = ~&i_word;
        o_pos   = '0;
        for (int j = bbal_pkg::WORD_W - 1; j >= 0; j--) begin
            if (!i_word[j]) begin
                o_pos = bbal_pkg::BIT_W'(j);
            end
        end
    end

endmodule

>>> sv/bitmap_block_allocator_top.sv
// Allocate: the map memory is read one 32-bit word per cycle into the find-first-zero
//   unit until the word holding the lowest free block is found, then S_EMIT responds.
// Request / release in range: map read, then read-modify-write (S_LOOK), then S_EMIT.
// One command at a time, next one taken as its response goes valid; the response register
//   lets it in while that response waits. Reset: synchronous, active low; init writes every map word.
`timescale 1ns / 1ps
`include "bitmap_block_allocator_top_assert.svh"

module bitmap_block_allocator_top #(
    parameter int NUM_BLOCKS     = bbal_pkg::NUM_BLOCKS_DEF,
    parameter int RESERVED_FIRST = bbal_pkg::RESERVED_FIRST_DEF,
    parameter int RESERVED_COUNT = bbal_pkg::RESERVED_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bbal_cmd_if.sink      i_cmd,
    bbal_rsp_if.source    o_rsp
);

    localparam int WORD_W    = bbal_pkg::WORD_W;
    localparam int BIT_W     = bbal_pkg::BIT_W;
    localparam int MAP_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IDX_W     = WADDR_W + BIT_W;
    localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
    localparam int RESV_END  = RESERVED_FIRST + RESERVED_COUNT;
    localparam int RESV_HI   = (RESV_END < NUM_BLOCKS) ? RESV_END : NUM_BLOCKS;
    localparam int RESV_USED = (RESV_HI > RESERVED_FIRST) ? RESV_HI - RESERVED_FIRST : 0;

    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(MAP_WORDS - 1);
    localparam logic [CNT_W-1:0]   NB_CNT    = CNT_W'(NUM_BLOCKS);
    localparam logic [CNT_W-1:0]   RESV_CNT  = CNT_W'(RESV_USED);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_LOOK,
        S_EMIT
    } t_state;

    t_state                        r_state;
    logic [WADDR_W-1:0]            r_init_addr;
    logic [WADDR_W-1:0]            r_scan_addr;
    logic                          r_issue_done;
    logic                          r_chk_vld;
    logic [WADDR_W-1:0]            r_chk_addr;
    bbal_pkg::t_cmd                r_cmd;
    logic [WADDR_W-1:0]            r_blk_word;
    logic [BIT_W-1:0]              r_blk_bit;
    logic [CNT_W-1:0]              r_used_cnt;
    bbal_pkg::t_status             r_res_status;
    logic [bbal_pkg::GRANT_W-1:0]  r_res_grant;
    logic                          r_out_valid;
    bbal_pkg::t_status             r_out_status;
    logic [bbal_pkg::GRANT_W-1:0]  r_out_grant;
    logic [bbal_pkg::TOTAL_W-1:0]  r_out_used;
    logic [bbal_pkg::TOTAL_W-1:0]  r_out_free;

    logic                          w_in_ready;
    logic                          w_in_range;
    logic [IDX_W-1:0]              w_blk_idx;
    logic [WORD_W-1:0]             w_init_word;
    logic                          w_we;
    logic [WADDR_W-1:0]            w_waddr;
    logic [WORD_W-1:0]             w_wdata;
    logic [WADDR_W-1:0]            w_raddr;
    logic [WORD_W-1:0]             w_rdata;
    logic                          w_ffz_found;
    logic [BIT_W-1:0]              w_ffz_pos;
    logic [WORD_W-1:0]             w_ffz_mask;
    logic [WORD_W-1:0]             w_blk_mask;
    logic                          w_blk_used;

    // Map memory and the find-first-zero unit
    bbal_map_ram #(
        .DEPTH  (MAP_WORDS),
        .ADDR_W (WADDR_W)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    bbal_ffz u_ffz (
        .i_word  (w_rdata),
        .o_found (w_ffz_found),
        .o_pos   (w_ffz_pos)
    );

    // Input decode
    assign w_in_ready = (r_state == S_IDLE);
    assign i_cmd.ready = w_in_ready;
    assign w_in_range = 32'(i_cmd.block_number) < 32'(NUM_BLOCKS);
    assign w_blk_idx  = IDX_W'(i_cmd.block_number);

    assign w_ffz_mask = WORD_W'(1) << w_ffz_pos;
    assign w_blk_mask = WORD_W'(1) << r_blk_bit;
    assign w_blk_used = w_rdata[r_blk_bit];

    // Initial map word: reserved blocks and padding past the last block read as used
    always_comb begin
        int b;
        for (int j = 0; j < WORD_W; j++) begin
            b = int'(r_init_addr) * WORD_W + j;
            w_init_word[j] = (b >= NUM_BLOCKS) || ((b >= RESERVED_FIRST) && (b < RESV_END));
        end
    end

    // Memory port control
    always_comb begin
        w_raddr = r_scan_addr;
        w_we    = 1'b0;
        w_waddr = r_chk_addr;
        w_wdata = w_rdata;
        case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_waddr = r_init_addr;
                w_wdata = w_init_word;
            end
            S_IDLE: begin
                w_raddr = w_blk_idx[IDX_W-1:BIT_W];
            end
            S_SCAN: begin
                if (r_chk_vld && w_ffz_found) begin
                    w_we    = 1'b1;
                    w_wdata = w_rdata | w_ffz_mask;
                end
            end
            S_LOOK: begin
                w_waddr = r_blk_word;
                if (r_cmd == bbal_pkg::CMD_REQUEST && !w_blk_used) begin
                    w_we    = 1'b1;
                    w_wdata = w_rdata | w_blk_mask;
                end else if (r_cmd == bbal_pkg::CMD_RELEASE && w_blk_used) begin
                    w_we    = 1'b1;
                    w_wdata = w_rdata & ~w_blk_mask;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer, counter and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_init_addr  <= '0;
            r_scan_addr  <= '0;
            r_issue_done <= 1'b0;
            r_chk_vld    <= 1'b0;
            r_used_cnt   <= RESV_CNT;
            r_out_valid  <= 1'b0;
        end else begin
            // S_EMIT sets or keeps the response valid itself
            if (o_rsp.ready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    if (r_init_addr == LAST_WORD) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_init_addr <= r_init_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd       <= i_cmd.command;
                        r_blk_word  <= w_blk_idx[IDX_W-1:BIT_W];
                        r_blk_bit   <= w_blk_idx[BIT_W-1:0];
                        r_res_grant <= '0;
                        case (i_cmd.command)
                            bbal_pkg::CMD_ALLOC: begin
                                r_scan_addr  <= '0;
                                r_issue_done <= 1'b0;
                                r_chk_vld    <= 1'b0;
                                r_state      <= S_SCAN;
                            end
                            bbal_pkg::CMD_REQUEST: begin
                                if (w_in_range) begin
                                    r_state <= S_LOOK;
                                end else begin
                                    r_res_status <= bbal_pkg::STAT_RANGE;
                                    r_state      <= S_EMIT;
                                end
                            end
                            bbal_pkg::CMD_RELEASE: begin
                                r_res_status <= bbal_pkg::STAT_OK;
                                r_state      <= w_in_range ? S_LOOK : S_EMIT;
                            end
                            default: begin
                                r_res_status <= bbal_pkg::STAT_OK;
                                r_state      <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // Issue one word read per cycle, check the word read last cycle
                    r_chk_vld  <= !r_issue_done;
                    r_chk_addr <= r_scan_addr;
                    if (!r_issue_done) begin
                        if (r_scan_addr == LAST_WORD) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_scan_addr <= r_scan_addr + 1'b1;
                        end
                    end
                    if (r_chk_vld) begin
                        if (w_ffz_found) begin
                            r_used_cnt   <= r_used_cnt + 1'b1;
                            r_res_status <= bbal_pkg::STAT_OK;
                            r_res_grant  <= bbal_pkg::GRANT_W'({r_chk_addr, w_ffz_pos});
                            r_state      <= S_EMIT;
                        end else if (r_chk_addr == LAST_WORD) begin
                            r_res_status <= bbal_pkg::STAT_NO_FREE;
                            r_state      <= S_EMIT;
                        end
                    end
                end
                S_LOOK: begin
                    if (r_cmd == bbal_pkg::CMD_REQUEST) begin
                        if (w_blk_used) begin
                            r_res_status <= bbal_pkg::STAT_IN_USE;
                        end else begin
                            r_res_status <= bbal_pkg::STAT_OK;
                            r_used_cnt   <= r_used_cnt + 1'b1;
                        end
                    end else if (w_blk_used) begin
                        r_used_cnt <= r_used_cnt - 1'b1;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_grant  <= r_res_grant;
                        r_out_used   <= bbal_pkg::TOTAL_W'(r_used_cnt);
                        r_out_free   <= bbal_pkg::TOTAL_W'(NB_CNT - r_used_cnt);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Response channel
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.granted_block = r_out_grant;
    assign o_rsp.used_total    = r_out_used;
    assign o_rsp.free_total    = r_out_free;

    // Checks
    `BBAL_ASSERT_SAME(a_cnt_bound, r_state != S_INIT, r_used_cnt <= NB_CNT,
        "used count above block count")
    `BBAL_ASSERT_SAME(a_totals_sum, o_rsp.valid,
        bbal_pkg::TOTAL_W'(o_rsp.used_total + o_rsp.free_total)
            == bbal_pkg::TOTAL_W'(NUM_BLOCKS),
        "used plus free totals mismatch")
    `BBAL_ASSERT_SAME(a_full_on_nofree,
        o_rsp.valid && (o_rsp.status == bbal_pkg::STAT_NO_FREE),
        (o_rsp.used_total == bbal_pkg::TOTAL_W'(NUM_BLOCKS)) && (o_rsp.granted_block == '0),
        "no-free status with free blocks left")
    `BBAL_ASSERT_NEXT(a_busy_after_accept, i_cmd.valid && w_in_ready, r_state != S_IDLE,
        "sequencer idle right after accepting a command")

endmodule
